// ===== rtl/glyph_code_remap_utf8_encode_core_defines.svh =====
// assertion macros for the glyph code remap and utf-8 encoder
`ifndef GLYPH_CODE_REMAP_UTF8_ENCODE_CORE_DEFINES_SVH
`define GLYPH_CODE_REMAP_UTF8_ENCODE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GCRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define GCRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define GCRU_ASSERT_IMP(lbl, ante, cons)
`define GCRU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/gcru_pkg.sv =====
// types, code constants and lookup tables for the glyph remap pipeline
`timescale 1ns / 1ps
package gcru_pkg;

  localparam int CODE_W = 21;

  localparam logic [1:0] ST_ENC   = 2'd0;
  localparam logic [1:0] ST_LIG   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_PLAIN_START = 2'd0;
  localparam logic [1:0] REG_PLAIN_END   = 2'd1;
  localparam logic [1:0] REG_PLAIN_DIST  = 2'd2;
  localparam logic [1:0] REG_CAPS_DIST   = 2'd3;

  localparam logic [CODE_W-1:0] GC_LDQUO  = 21'h00e669;
  localparam logic [CODE_W-1:0] GC_NDASH  = 21'h00e66f;
  localparam logic [CODE_W-1:0] GC_BULLET = 21'h00e674;
  localparam logic [CODE_W-1:0] GC_RDQUO  = 21'h00e677;
  localparam logic [CODE_W-1:0] GC_MDASH  = 21'h00e689;
  localparam logic [CODE_W-1:0] GC_DEGREE = 21'h00e6a0;
  localparam logic [CODE_W-1:0] GC_HYPHEN = 21'h00e6a4;
  localparam logic [CODE_W-1:0] GC_TIMES  = 21'h00e6a6;
  localparam logic [CODE_W-1:0] GC_LIG_FI  = 21'h00e66d;
  localparam logic [CODE_W-1:0] GC_LIG_FL  = 21'h00e66e;
  localparam logic [CODE_W-1:0] GC_LIG_FF  = 21'h00e70f;
  localparam logic [CODE_W-1:0] GC_LIG_FFI = 21'h00e710;
  localparam logic [CODE_W-1:0] GC_CAPS_LO = 21'h00e717;
  localparam logic [CODE_W-1:0] GC_CAPS_HI = 21'h00e72f;
  localparam logic [CODE_W-1:0] UNI_MAX    = 21'h10ffff;

  localparam logic [2:0] FIX_LDQUO  = 3'd0;
  localparam logic [2:0] FIX_NDASH  = 3'd1;
  localparam logic [2:0] FIX_BULLET = 3'd2;
  localparam logic [2:0] FIX_RDQUO  = 3'd3;
  localparam logic [2:0] FIX_MDASH  = 3'd4;
  localparam logic [2:0] FIX_DEGREE = 3'd5;
  localparam logic [2:0] FIX_HYPHEN = 3'd6;
  localparam logic [2:0] FIX_TIMES  = 3'd7;

  localparam logic [1:0] LIG_FI  = 2'd0;
  localparam logic [1:0] LIG_FL  = 2'd1;
  localparam logic [1:0] LIG_FF  = 2'd2;
  localparam logic [1:0] LIG_FFI = 2'd3;

  localparam logic [7:0] ASC_F = 8'h66;
  localparam logic [7:0] ASC_I = 8'h69;
  localparam logic [7:0] ASC_L = 8'h6c;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SUB,
    KIND_FIXED,
    KIND_LIG
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] delta;
    kind_t             kind;
    logic [2:0]        sel;
  } cls_t;

  typedef struct packed {
    logic [CODE_W-1:0] cp;
    logic              err;
    logic              lig;
    logic [1:0]        lig_sel;
  } map_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic [1:0]      status;
  } enc_t;

  function automatic logic [CODE_W-1:0] fixed_cp(input logic [2:0] sel);
    logic [CODE_W-1:0] cp;
    unique case (sel)
      FIX_LDQUO:  cp = 21'h00201c;
      FIX_NDASH:  cp = 21'h002013;
      FIX_BULLET: cp = 21'h002022;
      FIX_RDQUO:  cp = 21'h00201d;
      FIX_MDASH:  cp = 21'h002014;
      FIX_DEGREE: cp = 21'h0000b0;
      FIX_HYPHEN: cp = 21'h00002d;
      FIX_TIMES:  cp = 21'h0000d7;
      default:    cp = 21'h000000;
    endcase
    return cp;
  endfunction

endpackage

// ===== rtl/gcru_classify.sv =====
// first stage: range compares and fixed code and ligature decode
`timescale 1ns / 1ps
module gcru_classify
  import gcru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CODE_W-1:0] plain_start,
  input  logic [CODE_W-1:0] plain_end,
  input  logic [CODE_W-1:0] plain_dist,
  input  logic [CODE_W-1:0] caps_dist,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_code,
  output logic              out_valid,
  input  logic              out_ready,
  output cls_t              out_data
);

  logic valid_r;
  cls_t data_r;
  cls_t data_nxt;

  always_comb begin
    data_nxt      = '0;
    data_nxt.code = in_code;
    data_nxt.kind = KIND_PASS;
    if (in_code > plain_start && in_code < plain_end) begin
      data_nxt.kind  = KIND_SUB;
      data_nxt.delta = plain_dist;
    end else begin
      unique case (in_code)
        GC_LDQUO:   begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_LDQUO;  end
        GC_NDASH:   begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_NDASH;  end
        GC_BULLET:  begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_BULLET; end
        GC_RDQUO:   begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_RDQUO;  end
        GC_MDASH:   begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_MDASH;  end
        GC_DEGREE:  begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_DEGREE; end
        GC_HYPHEN:  begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_HYPHEN; end
        GC_TIMES:   begin data_nxt.kind = KIND_FIXED; data_nxt.sel = FIX_TIMES;  end
        GC_LIG_FI:  begin data_nxt.kind = KIND_LIG; data_nxt.sel = {1'b0, LIG_FI};  end
        GC_LIG_FL:  begin data_nxt.kind = KIND_LIG; data_nxt.sel = {1'b0, LIG_FL};  end
        GC_LIG_FF:  begin data_nxt.kind = KIND_LIG; data_nxt.sel = {1'b0, LIG_FF};  end
        GC_LIG_FFI: begin data_nxt.kind = KIND_LIG; data_nxt.sel = {1'b0, LIG_FFI}; end
        default: begin
          if (in_code >= GC_CAPS_LO && in_code <= GC_CAPS_HI) begin
            data_nxt.kind  = KIND_SUB;
            data_nxt.delta = caps_dist;
          end
        end
      endcase
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/gcru_remap.sv =====
// second stage: subtract distance or look up the corrected code point
`timescale 1ns / 1ps
module gcru_remap
  import gcru_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cls_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output map_t out_data
);

  logic            valid_r;
  map_t            data_r;
  map_t            data_nxt;
  logic [CODE_W:0] diff;

  assign diff = {1'b0, in_data.code} - {1'b0, in_data.delta};

  always_comb begin
    data_nxt = '0;
    unique case (in_data.kind)
      KIND_SUB: begin
        data_nxt.cp  = diff[CODE_W-1:0];
        data_nxt.err = diff[CODE_W];
      end
      KIND_FIXED: begin
        data_nxt.cp = fixed_cp(in_data.sel);
      end
      KIND_LIG: begin
        data_nxt.lig     = 1'b1;
        data_nxt.lig_sel = in_data.sel[1:0];
      end
      default: begin
        data_nxt.cp = in_data.code;
      end
    endcase
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/gcru_encode.sv =====
// third stage: utf-8 byte build, ligature spelling and range check
`timescale 1ns / 1ps
module gcru_encode
  import gcru_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  map_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output enc_t out_data
);

  logic              valid_r;
  enc_t              data_r;
  enc_t              data_nxt;
  logic [CODE_W-1:0] cp;

  assign cp = in_data.cp;

  always_comb begin
    data_nxt = '0;
    if (in_data.lig) begin
      data_nxt.status   = ST_LIG;
      data_nxt.bytes[0] = ASC_F;
      unique case (in_data.lig_sel)
        LIG_FI: begin
          data_nxt.bytes[1] = ASC_I;
          data_nxt.cnt      = 3'd2;
        end
        LIG_FL: begin
          data_nxt.bytes[1] = ASC_L;
          data_nxt.cnt      = 3'd2;
        end
        LIG_FF: begin
          data_nxt.bytes[1] = ASC_F;
          data_nxt.cnt      = 3'd2;
        end
        default: begin
          data_nxt.bytes[1] = ASC_F;
          data_nxt.bytes[2] = ASC_I;
          data_nxt.cnt      = 3'd3;
        end
      endcase
    end else if (in_data.err || cp > UNI_MAX) begin
      data_nxt.status = ST_RANGE;
      data_nxt.cnt    = 3'd1;
    end else begin
      data_nxt.status = ST_ENC;
      if (cp < 21'h000080) begin
        data_nxt.bytes[0] = {1'b0, cp[6:0]};
        data_nxt.cnt      = 3'd1;
      end else if (cp < 21'h000800) begin
        data_nxt.bytes[0] = {3'b110, cp[10:6]};
        data_nxt.bytes[1] = {2'b10, cp[5:0]};
        data_nxt.cnt      = 3'd2;
      end else if (cp < 21'h010000) begin
        data_nxt.bytes[0] = {4'b1110, cp[15:12]};
        data_nxt.bytes[1] = {2'b10, cp[11:6]};
        data_nxt.bytes[2] = {2'b10, cp[5:0]};
        data_nxt.cnt      = 3'd3;
      end else begin
        data_nxt.bytes[0] = {5'b11110, cp[20:18]};
        data_nxt.bytes[1] = {2'b10, cp[17:12]};
        data_nxt.bytes[2] = {2'b10, cp[11:6]};
        data_nxt.bytes[3] = {2'b10, cp[5:0]};
        data_nxt.cnt      = 3'd4;
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/gcru_serial.sv =====
// output stage: shifts the encoded bytes out one per cycle while out_ready is high
`timescale 1ns / 1ps
module gcru_serial
  import gcru_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  enc_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  output logic [1:0] out_status
);

  logic [3:0][7:0] buf_r;
  logic [2:0]      rem_r;
  logic [1:0]      status_r;

  assign out_valid     = (rem_r != 3'd0);
  assign out_byte      = buf_r[0];
  assign out_last_byte = (rem_r == 3'd1);
  assign out_status    = status_r;
  assign in_ready      = (rem_r == 3'd0) || (out_ready && rem_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else if (in_valid && in_ready) begin
      rem_r <= in_data.cnt;
    end else if (out_valid && out_ready) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_r    <= in_data.bytes;
      status_r <= in_data.status;
    end else if (out_valid && out_ready) begin
      buf_r <= {8'h00, buf_r[3:1]};
    end
  end

endmodule

// ===== rtl/glyph_code_remap_utf8_encode_core.sv =====
// path: a request passes the classify, remap and encode registers and the output byte shifter
// throughput: one byte per cycle while out_ready is high; a glyph is one to four bytes
// the output byte shifter sets the rate, the three stages ahead of it take a request each cycle unless stalled
// reset: synchronous active-low rst_n empties the pipeline and clears all config registers
`timescale 1ns / 1ps
`include "glyph_code_remap_utf8_encode_core_defines.svh"
module glyph_code_remap_utf8_encode_core
  import gcru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CODE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_glyph_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_byte,
  output logic [1:0]        out_status
);

  logic [CODE_W-1:0] plain_start_r;
  logic [CODE_W-1:0] plain_end_r;
  logic [CODE_W-1:0] plain_dist_r;
  logic [CODE_W-1:0] caps_dist_r;

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;
  cls_t s1_data;
  map_t s2_data;
  enc_t s3_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_start_r <= '0;
      plain_end_r   <= '0;
      plain_dist_r  <= '0;
      caps_dist_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAIN_START: plain_start_r <= cfg_wdata;
        REG_PLAIN_END:   plain_end_r   <= cfg_wdata;
        REG_PLAIN_DIST:  plain_dist_r  <= cfg_wdata;
        REG_CAPS_DIST:   caps_dist_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gcru_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .plain_start(plain_start_r),
    .plain_end  (plain_end_r),
    .plain_dist (plain_dist_r),
    .caps_dist  (caps_dist_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_code    (in_glyph_code),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  gcru_remap u_remap (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid),
    .in_ready (s1_ready),
    .in_data  (s1_data),
    .out_valid(s2_valid),
    .out_ready(s2_ready),
    .out_data (s2_data)
  );

  gcru_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid),
    .in_ready (s2_ready),
    .in_data  (s2_data),
    .out_valid(s3_valid),
    .out_ready(s3_ready),
    .out_data (s3_data)
  );

  gcru_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s3_valid),
    .in_ready     (s3_ready),
    .in_data      (s3_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte),
    .out_status   (out_status)
  );

  // bytes of one glyph follow each other with no gap
  `GCRU_ASSERT_NXT(a_glyph_contiguous, out_valid && out_ready && !out_last_byte, out_valid)
  // out of range gives a single empty byte
  `GCRU_ASSERT_IMP(a_range_empty, out_valid && out_status == ST_RANGE, out_last_byte && out_byte == 8'h00)
  // ligatures spell only f, i and l
  `GCRU_ASSERT_IMP(a_lig_letters, out_valid && out_status == ST_LIG, out_byte == ASC_F || out_byte == ASC_I || out_byte == ASC_L)

endmodule
